// File: design/qpr_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion point rotation package
// Shared widths and the record passed from the front end to the divider.
// ----------------------------------------------------------------------------
package qpr_pkg;

    localparam int QuatW  = 16;
    localparam int PointW = 24;
    localparam int NumW   = 60;
    localparam int DenW   = 34;
    localparam int QuotW  = 25;
    localparam int RemW   = 62;
    localparam int DivW   = DenW + 1;

    localparam logic [QuotW-1:0] PosLimit = 25'd8388607;
    localparam logic [QuotW-1:0] NegLimit = 25'd8388608;

    typedef struct packed {
        logic signed [NumW-1:0] num_x;
        logic signed [NumW-1:0] num_y;
        logic signed [NumW-1:0] num_z;
        logic        [DenW-1:0] den;
    } frac_t;

endpackage

// File: design/qpr_if.sv
// ----------------------------------------------------------------------------
// Quaternion point rotation channels
// Valid/ready interfaces for the input items and the rotated results.
// ----------------------------------------------------------------------------
interface qpr_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z,
                    point_x, point_y, point_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z,
                    point_x, point_y, point_z, output ready);
endinterface

interface qpr_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] rotated_x;
    logic signed [23:0] rotated_y;
    logic signed [23:0] rotated_z;
    logic               saturated;

    modport source (output valid, rotated_x, rotated_y, rotated_z, saturated,
                    input ready);
    modport sink   (input valid, rotated_x, rotated_y, rotated_z, saturated,
                    output ready);
endinterface

// File: design/qpr_front.sv
// ----------------------------------------------------------------------------
// Quaternion point rotation front end
// Four-stage pipeline forming the sandwich-product numerators and |q|^2.
// ----------------------------------------------------------------------------
module qpr_front
(
    input  logic           clk,
    input  logic           rst_n,
    qpr_in_if.sink         point_in,
    output logic           frac_valid,
    input  logic           frac_ready,
    output qpr_pkg::frac_t frac
);

    logic [3:0] vld_reg;
    logic       adv;

    logic signed [15:0] w1_reg, w2_reg;
    logic signed [15:0] u1_reg [3];
    logic signed [15:0] u2_reg [3];
    logic signed [23:0] p1_reg [3];
    logic signed [23:0] p2_reg [3];
    logic signed [31:0] sq_reg [4];
    logic signed [39:0] up_reg [3][3];
    logic        [33:0] den2_reg, den3_reg, den4_reg;
    logic signed [33:0] scal_reg;
    logic signed [41:0] dot_reg;
    logic signed [40:0] cr_reg [3];
    logic signed [57:0] m1_reg [3];
    logic signed [57:0] m2_reg [3];
    logic signed [57:0] m3_reg [3];
    logic signed [59:0] num_reg [3];

    logic signed [15:0] u_in [3];
    logic signed [23:0] p_in [3];

    assign adv = !vld_reg[3] || frac_ready;
    assign point_in.ready = adv;
    assign frac_valid = vld_reg[3];

    assign u_in[0] = point_in.quat_x;
    assign u_in[1] = point_in.quat_y;
    assign u_in[2] = point_in.quat_z;
    assign p_in[0] = point_in.point_x;
    assign p_in[1] = point_in.point_y;
    assign p_in[2] = point_in.point_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[2:0], point_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w1_reg    <= point_in.quat_w;
            sq_reg[0] <= 32'(point_in.quat_w) * 32'(point_in.quat_w);
            for (int i = 0; i < 3; i++)
            begin
                u1_reg[i] <= u_in[i];
                p1_reg[i] <= p_in[i];
                sq_reg[i+1] <= 32'(u_in[i]) * 32'(u_in[i]);
                for (int j = 0; j < 3; j++)
                begin
                    up_reg[i][j] <= 40'(u_in[i]) * 40'(p_in[j]);
                end
            end

            w2_reg   <= w1_reg;
            den2_reg <= 34'(sq_reg[0]) + 34'(sq_reg[1]) + 34'(sq_reg[2])
                        + 34'(sq_reg[3]);
            scal_reg <= 34'(sq_reg[0]) - (34'(sq_reg[1]) + 34'(sq_reg[2])
                        + 34'(sq_reg[3]));
            dot_reg  <= 42'(up_reg[0][0]) + 42'(up_reg[1][1]) + 42'(up_reg[2][2]);
            cr_reg[0] <= 41'(up_reg[1][2]) - 41'(up_reg[2][1]);
            cr_reg[1] <= 41'(up_reg[2][0]) - 41'(up_reg[0][2]);
            cr_reg[2] <= 41'(up_reg[0][1]) - 41'(up_reg[1][0]);
            for (int i = 0; i < 3; i++)
            begin
                u2_reg[i] <= u1_reg[i];
                p2_reg[i] <= p1_reg[i];
            end

            den3_reg <= den2_reg;
            for (int i = 0; i < 3; i++)
            begin
                m1_reg[i] <= 58'(scal_reg) * 58'(p2_reg[i]);
                m2_reg[i] <= 58'(dot_reg) * 58'(u2_reg[i]);
                m3_reg[i] <= 58'(w2_reg) * 58'(cr_reg[i]);
            end

            den4_reg <= den3_reg;
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= 60'(m1_reg[i]) + (60'(m2_reg[i]) <<< 1)
                              + (60'(m3_reg[i]) <<< 1);
            end
        end
    end

    assign frac.num_x = num_reg[0];
    assign frac.num_y = num_reg[1];
    assign frac.num_z = num_reg[2];
    assign frac.den   = den4_reg;

endmodule

// File: design/qpr_fifo.sv
// ----------------------------------------------------------------------------
// Quaternion point rotation queue
// Small register queue decoupling the front end from the divider.
// ----------------------------------------------------------------------------
module qpr_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  qpr_pkg::frac_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output qpr_pkg::frac_t pop_data
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    qpr_pkg::frac_t    mem_reg [DEPTH];
    logic [PtrW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [CntW-1:0]   cnt_reg, cnt_next;
    logic              push, pop;

    assign push_ready = (cnt_reg != CntW'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = (wr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        rd_next  = (rd_reg == PtrW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_reg <= wr_next;
            end
            if (pop)
            begin
                rd_reg <= rd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CntW'(DEPTH))
        else $error("queue count exceeds its depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a write");
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 |-> wr_reg == rd_reg)
        else $error("empty queue with unequal pointers");

endmodule

// File: design/qpr_back.sv
// ----------------------------------------------------------------------------
// Quaternion point rotation back end
// Pipelined restoring divider, one quotient bit a stage, with rounding and
// saturation to Q16.8.
// ----------------------------------------------------------------------------
module qpr_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           frac_valid,
    output logic           frac_ready,
    input  qpr_pkg::frac_t frac,
    qpr_out_if.source      point_out
);

    localparam int QW = qpr_pkg::QuotW;
    localparam int RW = qpr_pkg::RemW;
    localparam int DW = qpr_pkg::DivW;
    localparam int NS = QW + 1;

    logic          adv;
    logic [NS:0]   vld_reg;
    logic [RW-1:0] rem_reg [NS][3];
    logic [QW-1:0] quo_reg [NS][3];
    logic [2:0]    ovf_reg [NS];
    logic [2:0]    neg_reg [NS];
    logic [DW-1:0] div_reg [NS];
    logic          zero_reg [NS];

    logic signed [qpr_pkg::NumW-1:0] num_in [3];
    logic [qpr_pkg::NumW-1:0]        mag [3];
    logic [RW-1:0]                   nrm [3];
    logic [DW-1:0]                   div_in;

    logic signed [23:0] res_reg [3];
    logic               sat_reg;
    logic signed [23:0] res_next [3];
    logic [2:0]         clip;

    assign adv = !vld_reg[NS] || point_out.ready;
    assign frac_ready = adv;

    assign num_in[0] = frac.num_x;
    assign num_in[1] = frac.num_y;
    assign num_in[2] = frac.num_z;
    assign div_in = {frac.den, 1'b0};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = num_in[i][qpr_pkg::NumW-1] ? -num_in[i] : num_in[i];
            nrm[i] = {1'b0, mag[i], 1'b0} + RW'(frac.den);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-1:0], frac_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg[0]  <= div_in;
            zero_reg[0] <= (frac.den == '0);
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= nrm[i];
                quo_reg[0][i] <= '0;
                neg_reg[0][i] <= num_in[i][qpr_pkg::NumW-1];
                ovf_reg[0][i] <= nrm[i] >= (RW'(div_in) << QW);
            end
        end
    end

    for (genvar s = 1; s < NS; s++)
    begin : g_bit
        localparam int B = QW - s;
        logic [RW-1:0] trial;
        assign trial = RW'(div_reg[s-1]) << B;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[s]  <= div_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[s-1][i] >= trial)
                    begin
                        rem_reg[s][i] <= rem_reg[s-1][i] - trial;
                        quo_reg[s][i] <= quo_reg[s-1][i] | (QW'(1) << B);
                    end
                    else
                    begin
                        rem_reg[s][i] <= rem_reg[s-1][i];
                        quo_reg[s][i] <= quo_reg[s-1][i];
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            clip[i] = 1'b0;
            if (zero_reg[NS-1])
            begin
                res_next[i] = '0;
            end
            else if (neg_reg[NS-1][i])
            begin
                if (ovf_reg[NS-1][i] || quo_reg[NS-1][i] > qpr_pkg::NegLimit)
                begin
                    clip[i] = 1'b1;
                    res_next[i] = 24'sh800000;
                end
                else
                begin
                    res_next[i] = 24'(-quo_reg[NS-1][i]);
                end
            end
            else if (ovf_reg[NS-1][i] || quo_reg[NS-1][i] > qpr_pkg::PosLimit)
            begin
                clip[i] = 1'b1;
                res_next[i] = 24'sh7FFFFF;
            end
            else
            begin
                res_next[i] = 24'(quo_reg[NS-1][i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                res_reg[i] <= res_next[i];
            end
            sat_reg <= |clip;
        end
    end

    assign point_out.valid     = vld_reg[NS];
    assign point_out.rotated_x = res_reg[0];
    assign point_out.rotated_y = res_reg[1];
    assign point_out.rotated_z = res_reg[2];
    assign point_out.saturated = sat_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS-1] && adv && zero_reg[NS-1] |=> !sat_reg)
        else $error("zero quaternion flagged as saturated");
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("divider pipeline moved while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NS-1] && !ovf_reg[NS-1][0] |-> rem_reg[NS-1][0] < RW'(div_reg[NS-1]))
        else $error("divider remainder not reduced");

endmodule

// File: design/quaternion_point_rotation.sv
// ----------------------------------------------------------------------------
// Quaternion point rotation
// Rotates a Q16.8 point by the unit form of a Q1.14 quaternion.
// ----------------------------------------------------------------------------
// Channel    Role     Transaction contents
// point_in   sink     quat_w/x/y/z, point_x/y/z
// point_out  source   rotated_x/y/z, saturated
//
// One transaction is accepted per clock cycle when nothing stalls.
// The path runs through four front-end stages, the queue, one divider setup
// stage, 25 one-bit divider stages and the output register.
// Reset clears all valid flags and the queue; no clearing pass is needed.
// A stalled output freezes the divider while the front end keeps filling
// the queue until it is full.
// ----------------------------------------------------------------------------
module quaternion_point_rotation
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    qpr_in_if.sink     point_in,
    qpr_out_if.source  point_out
);

    logic           f_valid, f_ready, b_valid, b_ready;
    qpr_pkg::frac_t f_data, b_data;

    qpr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .point_in   (point_in),
        .frac_valid (f_valid),
        .frac_ready (f_ready),
        .frac       (f_data)
    );

    qpr_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    qpr_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .frac_valid (b_valid),
        .frac_ready (b_ready),
        .frac       (b_data),
        .point_out  (point_out)
    );

endmodule
